// ===== hdl/two_level_lru_writeback_cache_macros.svh =====
// Assertion macros shared by the cache modules
`ifndef TWO_LEVEL_LRU_WRITEBACK_CACHE_MACROS_SVH
`define TWO_LEVEL_LRU_WRITEBACK_CACHE_MACROS_SVH

// Same-cycle implication, checked out of reset
`define TLC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, checked out of reset
`define TLC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== hdl/tlc_pkg.sv =====
// Types, constants, LRU helper functions and a saturating adder for the two-level cache
package tlc_pkg;

	localparam int ADDR_W   = 48;
	localparam int OFS_W    = 6;
	localparam int L1_SETS  = 64;
	localparam int L2_SETS  = 512;
	localparam int WAYS     = 8;
	localparam int LINE_W   = ADDR_W - OFS_W;
	localparam int S1_W     = $clog2(L1_SETS);
	localparam int S2_W     = $clog2(L2_SETS);
	localparam int T1_W     = LINE_W - S1_W;
	localparam int T2_W     = LINE_W - S2_W;
	localparam int WAY_W    = $clog2(WAYS);
	localparam int AGE_W    = $clog2(WAYS);
	localparam int CNT_W    = 32;
	localparam int NUM_CNT  = 6;
	localparam int CLR_N    = (L1_SETS > L2_SETS) ? L1_SETS : L2_SETS;
	localparam int CLR_W    = $clog2(CLR_N);
	localparam int QDEPTH   = 2;
	localparam int QPTR_W   = $clog2(QDEPTH);

	// counter slots
	localparam int C_ACC = 0;
	localparam int C_WR  = 1;
	localparam int C_L1H = 2;
	localparam int C_L2H = 3;
	localparam int C_L2M = 4;
	localparam int C_WB  = 5;

	typedef logic [WAYS-1:0][AGE_W-1:0] age_t;

	typedef struct packed {
		logic [WAYS-1:0][T1_W-1:0] tag;
		logic [WAYS-1:0]           valid;
		age_t                      age;
		logic [WAYS-1:0]           dirty;
	} l1_row_t;

	typedef struct packed {
		logic [WAYS-1:0][T2_W-1:0] tag;
		logic [WAYS-1:0]           valid;
		age_t                      age;
		logic [WAYS-1:0]           dirty;
	} l2_row_t;

	typedef struct packed {
		logic [S1_W-1:0] s1;
		logic [T1_W-1:0] t1;
		logic [S2_W-1:0] s2;
		logic [T2_W-1:0] t2;
		logic            wr;
		logic            last;
	} req_t;

	typedef struct packed {
		logic                           l1_hit;
		logic                           l2_hit;
		logic                           l2_miss;
		logic [1:0]                     wbn;
		logic                           trace_end;
		logic [NUM_CNT-1:0][CNT_W-1:0]  cnt;
	} res_t;

	function automatic age_t reset_age();
		age_t a;
		for (int w = 0; w < WAYS; w++) begin
			a[w] = AGE_W'(w);
		end
		return a;
	endfunction

	// highest-numbered way at the oldest age, else way 0
	function automatic logic [WAY_W-1:0] oldest(input age_t a);
		logic [WAY_W-1:0] v;
		v = '0;
		for (int w = 0; w < WAYS; w++) begin
			if (a[w] == AGE_W'(WAYS - 1)) begin
				v = WAY_W'(w);
			end
		end
		return v;
	endfunction

	// make way w newest; ages below limit and below the oldest age grow by one
	function automatic age_t touch(input age_t a, input logic [WAY_W-1:0] w,
		input logic [AGE_W:0] limit);
		age_t n;
		n = a;
		for (int i = 0; i < WAYS; i++) begin
			if ({1'b0, a[i]} < limit && a[i] < AGE_W'(WAYS - 1)) begin
				n[i] = a[i] + 1'b1;
			end
		end
		n[w] = '0;
		return n;
	endfunction

	function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] c,
		input logic [1:0] by);
		logic [CNT_W:0] s;
		s = {1'b0, c} + (CNT_W + 1)'(by);
		return s[CNT_W] ? '1 : s[CNT_W-1:0];
	endfunction

endpackage

// ===== hdl/tlc_front.sv =====
// Front end: accepts accesses, splits the address into set and tag, queues them
module tlc_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [47:0]        address,
	input  logic               write_op,
	input  logic               last_in_trace,
	output logic               q_valid,
	output tlc_pkg::req_t      q_req,
	input  logic               q_pop
);
	import tlc_pkg::*;

	req_t                q_mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QPTR_W:0]     count_q;
	logic [LINE_W-1:0]   line;
	req_t                dec;
	logic                do_push;
	logic                do_pop;

	assign line = address[ADDR_W-1:OFS_W];

	always_comb begin
		dec.s1   = line[S1_W-1:0];
		dec.t1   = line[LINE_W-1:S1_W];
		dec.s2   = line[S2_W-1:0];
		dec.t2   = line[LINE_W-1:S2_W];
		dec.wr   = write_op;
		dec.last = last_in_trace;
	end

	assign full    = (count_q == (QPTR_W + 1)'(QDEPTH));
	assign q_valid = (count_q != '0);
	assign q_req   = q_mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = q_pop && q_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			q_mem_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (QPTR_W + 1)'(do_push) - (QPTR_W + 1)'(do_pop);
		end
	end

	`include "two_level_lru_writeback_cache_macros.svh"

	`TLC_ASSERT_NOW(a_q_bound, 1'b1, count_q <= (QPTR_W + 1)'(QDEPTH))

endmodule

// ===== hdl/tlc_back.sv =====
// Back end: tag memories, LRU update, write-back of L1 victims and trace counters
module tlc_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  tlc_pkg::req_t      q_req,
	output logic               q_pop,
	output logic               res_valid,
	output tlc_pkg::res_t      res,
	input  logic               res_pop
);
	import tlc_pkg::*;

	typedef enum logic [2:0] {
		S_CLR, S_IDLE, S_LOOK, S_VRD, S_VWB, S_DONE
	} state_t;

	state_t                        state_q;
	logic [CLR_W-1:0]              clr_q;
	req_t                          req_q;
	logic                          l1h_q, l2h_q, l2m_q;
	logic [1:0]                    wbn_q;
	logic [S2_W-1:0]               vs_q;
	logic [T2_W-1:0]               vt_q;
	logic [NUM_CNT-1:0][CNT_W-1:0] cnt_q;
	logic                          out_valid_q;
	res_t                          out_q;

	l1_row_t                       l1_mem [L1_SETS];
	l2_row_t                       l2_mem [L2_SETS];
	l1_row_t                       l1_rd_q;
	l2_row_t                       l2_rd_q;
	logic [S1_W-1:0]               l1_raddr;
	logic [S2_W-1:0]               l2_raddr;
	logic                          l1_we, l2_we;
	logic [S1_W-1:0]               l1_waddr;
	logic [S2_W-1:0]               l2_waddr;
	l1_row_t                       l1_wdata, l1_init;
	l2_row_t                       l2_wdata, l2_init;

	// lookup results
	logic                          hit1, hit2, hitv, vic, wb0, wbv;
	logic [WAY_W-1:0]              hw, h2, hv, v1, v2;
	logic [LINE_W-1:0]             vline;
	logic [NUM_CNT-1:0][CNT_W-1:0] cnt_nx;
	logic                          fin;

	always_comb begin
		l1_init       = '0;
		l1_init.age   = reset_age();
		l2_init       = '0;
		l2_init.age   = reset_age();
	end

	assign q_pop     = (state_q == S_IDLE) && q_valid;
	assign l1_raddr  = (state_q == S_IDLE) ? q_req.s1 : req_q.s1;
	assign l2_raddr  = (state_q == S_VRD) ? vs_q : q_req.s2;
	assign fin       = (state_q == S_DONE) && (!out_valid_q || res_pop);
	assign res_valid = out_valid_q;
	assign res       = out_q;

	always_ff @(posedge clk) begin
		l1_rd_q <= l1_mem[l1_raddr];
		l2_rd_q <= l2_mem[l2_raddr];
		if (l1_we) begin
			l1_mem[l1_waddr] <= l1_wdata;
		end
		if (l2_we) begin
			l2_mem[l2_waddr] <= l2_wdata;
		end
	end

	always_comb begin
		hit1 = 1'b0;
		hw   = '0;
		hit2 = 1'b0;
		h2   = '0;
		hitv = 1'b0;
		hv   = '0;
		for (int w = 0; w < WAYS; w++) begin
			if (l1_rd_q.valid[w] && l1_rd_q.tag[w] == req_q.t1) begin
				hit1 = 1'b1;
				hw   = WAY_W'(w);
			end
			if (l2_rd_q.valid[w] && l2_rd_q.tag[w] == req_q.t2) begin
				hit2 = 1'b1;
				h2   = WAY_W'(w);
			end
			if (l2_rd_q.valid[w] && l2_rd_q.tag[w] == vt_q) begin
				hitv = 1'b1;
				hv   = WAY_W'(w);
			end
		end
		v1    = oldest(l1_rd_q.age);
		v2    = oldest(l2_rd_q.age);
		vic   = l1_rd_q.valid[v1] && l1_rd_q.dirty[v1];
		wb0   = l2_rd_q.valid[v2] && l2_rd_q.dirty[v2];
		wbv   = wb0;
		vline = {l1_rd_q.tag[v1], req_q.s1};
	end

	always_comb begin
		l1_we    = 1'b0;
		l2_we    = 1'b0;
		l1_waddr = req_q.s1;
		l2_waddr = req_q.s2;
		l1_wdata = l1_rd_q;
		l2_wdata = l2_rd_q;
		unique case (state_q)
			S_CLR: begin
				l1_we    = ({1'b0, clr_q} < (CLR_W + 1)'(L1_SETS));
				l2_we    = ({1'b0, clr_q} < (CLR_W + 1)'(L2_SETS));
				l1_waddr = clr_q[S1_W-1:0];
				l2_waddr = clr_q[S2_W-1:0];
				l1_wdata = l1_init;
				l2_wdata = l2_init;
			end
			S_LOOK: begin
				l1_we = 1'b1;
				if (hit1) begin
					l1_wdata.age = touch(l1_rd_q.age, hw, {1'b0, l1_rd_q.age[hw]});
					if (req_q.wr) begin
						l1_wdata.dirty[hw] = 1'b1;
					end
				end else begin
					l2_we = 1'b1;
					if (hit2) begin
						l2_wdata.age = touch(l2_rd_q.age, h2, {1'b0, l2_rd_q.age[h2]});
					end else begin
						l2_wdata.tag[v2]   = req_q.t2;
						l2_wdata.valid[v2] = 1'b1;
						l2_wdata.dirty[v2] = 1'b0;
						l2_wdata.age       = touch(l2_rd_q.age, v2, (AGE_W + 1)'(WAYS));
					end
					l1_wdata.tag[v1]   = req_q.t1;
					l1_wdata.valid[v1] = 1'b1;
					l1_wdata.dirty[v1] = req_q.wr;
					l1_wdata.age       = touch(l1_rd_q.age, v1, (AGE_W + 1)'(WAYS));
				end
			end
			S_VWB: begin
				l2_we    = 1'b1;
				l2_waddr = vs_q;
				if (hitv) begin
					l2_wdata.dirty[hv] = 1'b1;
				end else begin
					l2_wdata.tag[v2]   = vt_q;
					l2_wdata.valid[v2] = 1'b1;
					l2_wdata.dirty[v2] = 1'b1;
					l2_wdata.age       = touch(l2_rd_q.age, v2, (AGE_W + 1)'(WAYS));
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		cnt_nx        = cnt_q;
		cnt_nx[C_ACC] = sat_add(cnt_q[C_ACC], 2'd1);
		cnt_nx[C_WR]  = sat_add(cnt_q[C_WR], {1'b0, req_q.wr});
		cnt_nx[C_L1H] = sat_add(cnt_q[C_L1H], {1'b0, l1h_q});
		cnt_nx[C_L2H] = sat_add(cnt_q[C_L2H], {1'b0, l2h_q});
		cnt_nx[C_L2M] = sat_add(cnt_q[C_L2M], {1'b0, l2m_q});
		cnt_nx[C_WB]  = sat_add(cnt_q[C_WB], wbn_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			l1h_q       <= 1'b0;
			l2h_q       <= 1'b0;
			l2m_q       <= 1'b0;
			wbn_q       <= '0;
		end else begin
			// drop the result once taken, unless a new one replaces it
			if (out_valid_q && res_pop && !fin) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CLR_W'(CLR_N - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (q_valid) begin
						req_q   <= q_req;
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					l1h_q <= hit1;
					l2h_q <= !hit1 && hit2;
					l2m_q <= !hit1 && !hit2;
					wbn_q <= {1'b0, !hit1 && !hit2 && wb0};
					vs_q  <= vline[S2_W-1:0];
					vt_q  <= vline[LINE_W-1:S2_W];
					state_q <= (!hit1 && vic) ? S_VRD : S_DONE;
				end
				S_VRD: begin
					state_q <= S_VWB;
				end
				S_VWB: begin
					wbn_q   <= wbn_q + {1'b0, !hitv && wbv};
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (fin) begin
						out_valid_q     <= 1'b1;
						out_q.l1_hit    <= l1h_q;
						out_q.l2_hit    <= l2h_q;
						out_q.l2_miss   <= l2m_q;
						out_q.wbn       <= wbn_q;
						out_q.trace_end <= req_q.last;
						out_q.cnt       <= cnt_nx;
						cnt_q           <= req_q.last ? '0 : cnt_nx;
						state_q         <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`include "two_level_lru_writeback_cache_macros.svh"

	`TLC_ASSERT_NOW(a_no_pop_in_clear, state_q == S_CLR, !q_pop)
	`TLC_ASSERT_NOW(a_one_outcome, out_valid_q,
		$onehot({out_q.l1_hit, out_q.l2_hit, out_q.l2_miss}))
	`TLC_ASSERT_NOW(a_hit_no_wb, out_valid_q && out_q.l1_hit, out_q.wbn == 2'd0)
	`TLC_ASSERT_NEXT(a_look_follows_pop, q_pop, state_q == S_LOOK)

endmodule

// ===== hdl/two_level_lru_writeback_cache.sv =====
// Two-level LRU write-back cache tag model: top level
// Input channel: drive address, write_op and last_in_trace with push; an
// access is taken at a clock edge where push is high and full is low. A
// two-entry queue sits behind the input, so up to two accesses may wait.
// Result channel: while empty is low the oldest result is on the result
// ports; it is taken at an edge where pop is high and empty is low. Each
// access gives exactly one result, in order.
// Flow: an L1 hit, or an L1 miss whose victim is clean, goes through the
// back end states LOOK and DONE; a miss with a dirty L1 victim also goes
// through VRD and VWB, since the victim's L2 set is read again after the
// first L2 update. The tag memories have one read and one write port each.
// The back end handles one access at a time, from IDLE back to IDLE.
// Reset: all tags invalid, ages at the way index, counters zero. After reset
// a clearing pass writes every tag set; accesses are queued but not
// processed until it ends.
// Stall: a result not popped holds the back end in its last step; the
// queue then fills and full rises.
module two_level_lru_writeback_cache (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [47:0] address,
	input  logic        write_op,
	input  logic        last_in_trace,
	output logic        empty,
	input  logic        pop,
	output logic        l1_hit,
	output logic        l2_hit,
	output logic        l2_miss,
	output logic [1:0]  writebacks_now,
	output logic        trace_end,
	output logic [31:0] access_count,
	output logic [31:0] write_count,
	output logic [31:0] l1_hit_count,
	output logic [31:0] l2_hit_count,
	output logic [31:0] l2_miss_count,
	output logic [31:0] writeback_count
);
	import tlc_pkg::*;

	logic q_valid;
	req_t q_req;
	logic q_pop;
	logic res_valid;
	res_t res;

	tlc_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.address       (address),
		.write_op      (write_op),
		.last_in_trace (last_in_trace),
		.q_valid       (q_valid),
		.q_req         (q_req),
		.q_pop         (q_pop)
	);

	tlc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_req     (q_req),
		.q_pop     (q_pop),
		.res_valid (res_valid),
		.res       (res),
		.res_pop   (pop)
	);

	assign empty           = !res_valid;
	assign l1_hit          = res.l1_hit;
	assign l2_hit          = res.l2_hit;
	assign l2_miss         = res.l2_miss;
	assign writebacks_now  = res.wbn;
	assign trace_end       = res.trace_end;
	assign access_count    = res.cnt[C_ACC];
	assign write_count     = res.cnt[C_WR];
	assign l1_hit_count    = res.cnt[C_L1H];
	assign l2_hit_count    = res.cnt[C_L2H];
	assign l2_miss_count   = res.cnt[C_L2M];
	assign writeback_count = res.cnt[C_WB];

endmodule
